/* src/tfnd_pkg.sv */
// shared types, constants and bit permutations of the fingering note decoder
`default_nettype none

package tfnd_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned STATUS_W    = 8;
    localparam int unsigned FINGER_W    = 9;
    localparam int unsigned CONTROL_W   = 3;
    localparam int unsigned NOTE_W      = 8;
    localparam int unsigned MASK_W      = 16;
    localparam int unsigned SCAN_START  = 2;
    localparam int unsigned PATTERN_BIT = 31;

    localparam logic [WORD_W-1:0] END_MARK  = 32'hFFFF_FFFF;
    localparam logic [NOTE_W-1:0] NOT_FOUND = 8'hFF;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } tfnd_state_t;

    typedef struct packed {
        logic load_item;
        logic write_word;
        logic scan_run;
        logic load_result;
    } tfnd_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } tfnd_stat_t;

    function automatic logic [FINGER_W-1:0] permute_fingers(
        input logic [STATUS_W-1:0] lo,
        input logic [STATUS_W-1:0] hi
    );
        permute_fingers = {hi[3], hi[1], hi[2], lo[6], lo[7], lo[4], lo[2], lo[1], lo[0]};
    endfunction

    function automatic logic [CONTROL_W-1:0] permute_control(
        input logic [STATUS_W-1:0] lo,
        input logic [STATUS_W-1:0] hi
    );
        permute_control = {hi[0], lo[3], lo[5]};
    endfunction

endpackage

`default_nettype wire

/* src/tfnd_in_if.sv */
// request channel of the fingering note decoder
`default_nettype none

interface tfnd_in_if;
    import tfnd_pkg::*;

    logic                valid;
    logic                ready;
    logic                mode;
    logic [IDX_W-1:0]    word_index;
    logic [WORD_W-1:0]   word_value;
    logic [STATUS_W-1:0] status_low;
    logic [STATUS_W-1:0] status_high;

    modport source (
        output valid, mode, word_index, word_value, status_low, status_high,
        input  ready
    );
    modport sink (
        input  valid, mode, word_index, word_value, status_low, status_high,
        output ready
    );
endinterface

`default_nettype wire

/* src/tfnd_out_if.sv */
// result channel of the fingering note decoder
`default_nettype none

interface tfnd_out_if;
    import tfnd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [FINGER_W-1:0]  finger_bits;
    logic [CONTROL_W-1:0] control_bits;
    logic [NOTE_W-1:0]    note_out;
    logic                 found;

    modport source (
        output valid, finger_bits, control_bits, note_out, found,
        input  ready
    );
    modport sink (
        input  valid, finger_bits, control_bits, note_out, found,
        output ready
    );
endinterface

`default_nettype wire

/* src/tfnd_ctrl.sv */
// controller state machine: accepts requests, runs the table scan, hands off results
`default_nettype none

module tfnd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_mode,
    output logic                    req_ready,
    input  wire tfnd_pkg::tfnd_stat_t stat,
    output tfnd_pkg::tfnd_cmd_t     cmd
);
    import tfnd_pkg::*;

    tfnd_state_t state_reg;
    tfnd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.write_word = (req_mode == MODE_WRITE);
                    state_next     = (req_mode == MODE_DECODE) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/tfnd_datapath.sv */
// datapath: fingering table memory, scan pipeline, result and output registers
`default_nettype none

module tfnd_datapath #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tfnd_pkg::tfnd_cmd_t            cmd,
    output tfnd_pkg::tfnd_stat_t                stat,
    input  wire logic                           req_mode,
    input  wire logic [tfnd_pkg::IDX_W-1:0]     req_word_index,
    input  wire logic [tfnd_pkg::WORD_W-1:0]    req_word_value,
    input  wire logic [tfnd_pkg::STATUS_W-1:0]  req_status_low,
    input  wire logic [tfnd_pkg::STATUS_W-1:0]  req_status_high,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output logic [tfnd_pkg::FINGER_W-1:0]       rsp_finger_bits,
    output logic [tfnd_pkg::CONTROL_W-1:0]      rsp_control_bits,
    output logic [tfnd_pkg::NOTE_W-1:0]         rsp_note_out,
    output logic                                rsp_found
);
    import tfnd_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [WORD_W-1:0] mem [TABLE_DEPTH];

    logic [WORD_W-1:0]    base_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 pipe_valid_reg;
    logic                 skip_reg;
    logic [FINGER_W-1:0]  finger_reg;
    logic [CONTROL_W-1:0] control_reg;
    logic [NOTE_W-1:0]    note_reg;
    logic                 found_reg;

    logic                 rsp_valid_reg;
    logic [FINGER_W-1:0]  rsp_finger_reg;
    logic [CONTROL_W-1:0] rsp_control_reg;
    logic [NOTE_W-1:0]    rsp_note_reg;
    logic                 rsp_found_reg;

    logic [31:0]   widx_ext;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          eval;
    logic          is_pattern;
    logic          pat_match;
    logic          terminator;
    logic          note_hit;
    logic          last_word;

    assign widx_ext = 32'(req_word_index);
    assign wr_en    = cmd.write_word && (widx_ext < 32'(TABLE_DEPTH));
    assign wr_addr  = widx_ext[AW-1:0];

    // word under test is the one read in the previous scan cycle
    assign eval       = cmd.scan_run && pipe_valid_reg;
    assign is_pattern = rd_data_reg[PATTERN_BIT];
    assign pat_match  = is_pattern &&
                        ((MASK_W'(finger_reg) & rd_data_reg[MASK_W-1:0]) ==
                         {1'b0, rd_data_reg[PATTERN_BIT-1:MASK_W]});
    assign terminator = !skip_reg && (rd_data_reg == END_MARK);
    assign note_hit   = skip_reg && !is_pattern;
    assign last_word  = (rd_idx_reg == AW'(TABLE_DEPTH - 1));

    assign stat.scan_done = eval && (terminator || note_hit || last_word);
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_word_value;
        end
        if (cmd.scan_run)
        begin
            rd_data_reg <= mem[rd_addr_reg];
            rd_idx_reg  <= rd_addr_reg;
        end
    end

    // copy of word 0 so the base needs no extra read port
    always_ff @(posedge clk)
    begin
        if (wr_en && (widx_ext == 32'd0))
        begin
            base_reg <= req_word_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
            skip_reg       <= 1'b0;
            rd_addr_reg    <= '0;
        end
        else if (cmd.load_item)
        begin
            pipe_valid_reg <= 1'b0;
            skip_reg       <= 1'b0;
            rd_addr_reg    <= AW'(SCAN_START);
        end
        else if (cmd.scan_run)
        begin
            pipe_valid_reg <= 1'b1;
            rd_addr_reg    <= rd_addr_reg + AW'(1);
            if (eval && !skip_reg && !terminator && pat_match)
            begin
                skip_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            if (req_mode == MODE_DECODE)
            begin
                finger_reg  <= permute_fingers(req_status_low, req_status_high);
                control_reg <= permute_control(req_status_low, req_status_high);
                note_reg    <= NOT_FOUND;
            end
            else
            begin
                finger_reg  <= '0;
                control_reg <= '0;
                note_reg    <= '0;
            end
            found_reg <= 1'b0;
        end
        else if (eval && note_hit)
        begin
            note_reg  <= base_reg[NOTE_W-1:0] + rd_data_reg[WORD_W-1 -: NOTE_W];
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            rsp_finger_reg  <= finger_reg;
            rsp_control_reg <= control_reg;
            rsp_note_reg    <= note_reg;
            rsp_found_reg   <= found_reg;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign rsp_finger_bits  = rsp_finger_reg;
    assign rsp_control_bits = rsp_control_reg;
    assign rsp_note_out     = rsp_note_reg;
    assign rsp_found        = rsp_found_reg;

endmodule

`default_nettype wire

/* src/touch_fingering_note_decoder.sv */
// Touch fingering note decoder. Each request either writes one 32-bit word of the
// fingering table (mode 0) or decodes two touch status bytes into finger and control
// bits and looks the fingers up in the table (mode 1). A table write loads its
// all-zero result into the output register once that register is free. A decode
// reads the table one word per cycle through the single read port of the table
// memory, starting at word 2, examines at most TABLE_DEPTH - 2 words and then loads
// its result into the output register once that register is free. One request is
// in flight at a time; a finished result waits in the output register, and the
// next request is taken as soon as the block returns to idle. Table words are
// undefined until written, so a decode must never reach a word that has not been
// written.
`default_nettype none

module touch_fingering_note_decoder #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tfnd_in_if.sink     req,
    tfnd_out_if.source  rsp
);
    import tfnd_pkg::*;

    tfnd_cmd_t  cmd;
    tfnd_stat_t stat;

    tfnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tfnd_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .req_mode         (req.mode),
        .req_word_index   (req.word_index),
        .req_word_value   (req.word_value),
        .req_status_low   (req.status_low),
        .req_status_high  (req.status_high),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_finger_bits  (rsp.finger_bits),
        .rsp_control_bits (rsp.control_bits),
        .rsp_note_out     (rsp.note_out),
        .rsp_found        (rsp.found)
    );

endmodule

`default_nettype wire

/* src/tfnd_checker.sv */
// port-level checker for the fingering note decoder and its bind
`default_nettype none

module tfnd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             req_valid,
    input wire logic                             req_ready,
    input wire logic                             rsp_valid,
    input wire logic                             rsp_ready,
    input wire logic [tfnd_pkg::FINGER_W-1:0]    rsp_finger_bits,
    input wire logic [tfnd_pkg::CONTROL_W-1:0]   rsp_control_bits,
    input wire logic [tfnd_pkg::NOTE_W-1:0]      rsp_note_out,
    input wire logic                             rsp_found
);
    import tfnd_pkg::*;

    // a stalled result holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_note_out) &&
        $stable(rsp_found) && $stable(rsp_finger_bits) && $stable(rsp_control_bits))
        else $error("result changed while stalled");

    // only one request in flight
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

    // a new result only appears while no request can be taken
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("result appeared without work in progress");

    // a miss is either a write acknowledge or the not-found note
    a_miss_note: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> (rsp_note_out == NOT_FOUND) ||
        (rsp_note_out == '0 && rsp_finger_bits == '0 && rsp_control_bits == '0))
        else $error("bad note on a miss");

endmodule

bind touch_fingering_note_decoder tfnd_checker u_tfnd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_finger_bits  (rsp.finger_bits),
    .rsp_control_bits (rsp.control_bits),
    .rsp_note_out     (rsp.note_out),
    .rsp_found        (rsp.found)
);

`default_nettype wire

/* bench/tb_touch_fingering_note_decoder.sv */
// testbench of the touch fingering note decoder: directed rows, then random table layouts
`timescale 1ns / 100ps

module tb_touch_fingering_note_decoder;
    import tfnd_pkg::*;

    localparam int DEPTH        = 64;
    localparam int ITEM_TARGET  = 1050;
    localparam int DIRECTED_N   = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TAIL_CYCLES  = DEPTH + 16;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 4;
    localparam int PRINT_LIMIT  = 30;

    localparam logic CHK = 1'b1;
    localparam logic PRD = 1'b0;

    localparam logic [WORD_W-1:0] CATCH_ALL = 32'h8000_0000;

    typedef struct packed {
        logic                mode;
        logic [IDX_W-1:0]    word_index;
        logic [WORD_W-1:0]   word_value;
        logic [STATUS_W-1:0] status_low;
        logic [STATUS_W-1:0] status_high;
    } touch_req_t;

    typedef struct packed {
        logic [FINGER_W-1:0]  finger_bits;
        logic [CONTROL_W-1:0] control_bits;
        logic [NOTE_W-1:0]    note_out;
        logic                 found;
    } note_result_t;

    typedef struct packed {
        logic         typed;
        touch_req_t   rq;
        note_result_t exp;
    } dir_row_t;

    typedef struct packed {
        logic              hit;
        logic [NOTE_W-1:0] note;
        logic              reads_ok;
    } scan_outcome_t;

    typedef enum logic [1:0] {
        LAYOUT_TERMINATED,
        LAYOUT_NO_END,
        LAYOUT_RUN_TO_END
    } layout_t;

    localparam note_result_t ZERO_RESULT = '0;

    logic clk;
    logic rst_n;

    tfnd_in_if  req_ch ();
    tfnd_out_if rsp_ch ();

    touch_fingering_note_decoder #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [WORD_W-1:0] fingering_shadow [DEPTH];
    logic [DEPTH-1:0]  word_written;
    note_result_t      notes_due [$];

    int  error_count     = 0;
    int  results_checked = 0;
    int  requests_sent   = 0;
    int  writes_seen     = 0;
    int  decodes_seen    = 0;
    int  hits_seen       = 0;
    int  cycle_count     = 0;
    logic in_calm        = 1'b0;
    logic out_calm       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 notes_due.size());
        $display("status: fail");
        $finish;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] error: %s", $time, msg);
    endtask

    function automatic logic [FINGER_W-1:0] fingers_of(input logic [7:0] lo,
                                                       input logic [7:0] hi);
        logic [FINGER_W-1:0] f;
        f[0] = lo[0];
        f[1] = lo[1];
        f[2] = lo[2];
        f[3] = lo[4];
        f[4] = lo[7];
        f[5] = lo[6];
        f[6] = hi[2];
        f[7] = hi[1];
        f[8] = hi[3];
        return f;
    endfunction

    function automatic logic [CONTROL_W-1:0] controls_of(input logic [7:0] lo,
                                                         input logic [7:0] hi);
        logic [CONTROL_W-1:0] c;
        c[0] = lo[5];
        c[1] = lo[3];
        c[2] = hi[0];
        return c;
    endfunction

    // status bytes that press exactly the given fingers, other bits random
    function automatic logic [15:0] status_for_fingers(input logic [FINGER_W-1:0] f);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        lo[0] = f[0];
        lo[1] = f[1];
        lo[2] = f[2];
        lo[4] = f[3];
        lo[7] = f[4];
        lo[6] = f[5];
        hi[2] = f[6];
        hi[1] = f[7];
        hi[3] = f[8];
        return {hi, lo};
    endfunction

    // walk the shadow table; reads_ok drops if any word touched was never written
    function automatic scan_outcome_t scan_fingering(input logic [FINGER_W-1:0] fingers);
        scan_outcome_t r;
        logic [WORD_W-1:0] w;
        logic stop;
        logic matched;
        int i;
        r.hit      = 1'b0;
        r.note     = NOT_FOUND;
        r.reads_ok = word_written[0];
        stop       = 1'b0;
        matched    = 1'b0;
        i          = SCAN_START;
        while (!stop && i < DEPTH)
        begin
            r.reads_ok = r.reads_ok & word_written[i];
            w = fingering_shadow[i];
            if (w == END_MARK)
                stop = 1'b1;
            else if (w[PATTERN_BIT] &&
                     (({7'd0, fingers} & w[MASK_W-1:0]) == {1'b0, w[30:16]}))
            begin
                matched = 1'b1;
                stop    = 1'b1;
            end
            else
                i++;
        end
        if (matched)
        begin
            // skip the rest of the pattern run, terminator words included
            while (i < DEPTH && fingering_shadow[i][PATTERN_BIT])
            begin
                r.reads_ok = r.reads_ok & word_written[i];
                i++;
            end
            if (i < DEPTH)
            begin
                r.reads_ok = r.reads_ok & word_written[i];
                r.hit      = 1'b1;
                r.note     = fingering_shadow[0][7:0] + fingering_shadow[i][31:24];
            end
        end
        return r;
    endfunction

    function automatic note_result_t predict_touch_result(input touch_req_t rq);
        note_result_t r;
        scan_outcome_t s;
        r = '0;
        if (rq.mode == MODE_WRITE)
        begin
            fingering_shadow[rq.word_index] = rq.word_value;
            word_written[rq.word_index]     = 1'b1;
            writes_seen++;
        end
        else
        begin
            r.finger_bits  = fingers_of(rq.status_low, rq.status_high);
            r.control_bits = controls_of(rq.status_low, rq.status_high);
            s              = scan_fingering(r.finger_bits);
            r.note_out     = s.hit ? s.note : NOT_FOUND;
            r.found        = s.hit;
            decodes_seen++;
            if (s.hit)
                hits_seen++;
        end
        return r;
    endfunction

    function automatic logic decode_is_safe(input logic [7:0] lo, input logic [7:0] hi);
        scan_outcome_t s;
        s = scan_fingering(fingers_of(lo, hi));
        return s.reads_ok;
    endfunction

    function automatic touch_req_t random_request();
        touch_req_t rq;
        rq.mode        = 1'($urandom);
        rq.word_index  = 6'($urandom);
        rq.word_value  = $urandom;
        rq.status_low  = 8'($urandom);
        rq.status_high = 8'($urandom);
        return rq;
    endfunction

    function automatic logic [WORD_W-1:0] live_pattern();
        logic [MASK_W-1:0] m;
        logic [14:0] v;
        logic [WORD_W-1:0] w;
        m = 16'($urandom & $urandom & $urandom);
        if ($urandom_range(0, 9) == 0)
            m = 16'($urandom);
        v = 15'(m) & 15'($urandom);
        if ($urandom_range(0, 7) == 0)
            v = 15'($urandom);
        w = {1'b1, v, m};
        if (w == END_MARK)
            w[0] = 1'b0;
        return w;
    endfunction

    // expects finger bit 12, which never exists, so it can never match
    function automatic logic [WORD_W-1:0] dead_pattern();
        logic [WORD_W-1:0] w;
        w = live_pattern() | 32'h1000_1000;
        if (w == END_MARK)
            w[0] = 1'b0;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] note_word();
        return {1'b0, 31'($urandom)};
    endfunction

    // directed rows: typed expectation, request, expected result
    function automatic dir_row_t directed_row(input int n);
        dir_row_t r;
        case (n)
            0:  r = {CHK, MODE_WRITE, 6'd0, 32'h0000_0000, 8'h00, 8'h00, ZERO_RESULT};
            1:  r = {CHK, MODE_WRITE, 6'd2, END_MARK, 8'h00, 8'h00, ZERO_RESULT};
            2:  r = {CHK, MODE_DECODE, 6'd0, 32'h0, 8'h00, 8'h00,
                     9'h000, 3'd0, NOT_FOUND, 1'b0};
            3:  r = {CHK, MODE_DECODE, 6'd63, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                     9'h1FF, 3'd7, NOT_FOUND, 1'b0};
            4:  r = {PRD, MODE_WRITE, 6'd0, 32'hFFFF_FFF0, 8'h00, 8'h00, ZERO_RESULT};
            // all nine fingers down
            5:  r = {PRD, MODE_WRITE, 6'd2, 32'h81FF_01FF, 8'h00, 8'h00, ZERO_RESULT};
            // first finger only, skipped when word 2 already matched
            6:  r = {PRD, MODE_WRITE, 6'd3, 32'h8001_0001, 8'h00, 8'h00, ZERO_RESULT};
            7:  r = {PRD, MODE_WRITE, 6'd4, 32'h7F00_0000, 8'h00, 8'h00, ZERO_RESULT};
            8:  r = {PRD, MODE_WRITE, 6'd5, CATCH_ALL, 8'h00, 8'h00, ZERO_RESULT};
            9:  r = {PRD, MODE_WRITE, 6'd6, 32'h0100_0000, 8'h00, 8'h00, ZERO_RESULT};
            10: r = {PRD, MODE_WRITE, 6'd7, END_MARK, 8'h00, 8'h00, ZERO_RESULT};
            11: r = {PRD, MODE_DECODE, 6'd0, 32'h0, 8'hFF, 8'hFF, ZERO_RESULT};
            12: r = {PRD, MODE_DECODE, 6'd0, 32'h0, 8'h01, 8'h00, ZERO_RESULT};
            13: r = {PRD, MODE_DECODE, 6'd0, 32'h0, 8'h00, 8'h00, ZERO_RESULT};
            14: r = {CHK, MODE_WRITE, 6'd0, 32'hFFFF_FFFF, 8'h00, 8'h00, ZERO_RESULT};
            // base 0xff plus note 0x7f wraps
            15: r = {PRD, MODE_DECODE, 6'd21, 32'h0, 8'hFF, 8'h0F, ZERO_RESULT};
            16: r = {PRD, MODE_WRITE, 6'd63, 32'h5A5A_A5A5, 8'hFF, 8'hFF, ZERO_RESULT};
            17: r = {PRD, MODE_WRITE, 6'd1, 32'h0000_0000, 8'h00, 8'h00, ZERO_RESULT};
            18: r = {PRD, MODE_DECODE, 6'd42, 32'hFFFF_FFFF, 8'h2A, 8'h05, ZERO_RESULT};
            default: r = {PRD, MODE_DECODE, 6'd0, 32'h0, 8'h80, 8'h08, ZERO_RESULT};
        endcase
        return r;
    endfunction

    task automatic send_request(input touch_req_t rq, input logic typed,
                                input note_result_t typed_exp);
        int gap;
        note_result_t predicted;
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= rq.mode;
        req_ch.word_index  <= rq.word_index;
        req_ch.word_value  <= rq.word_value;
        req_ch.status_low  <= rq.status_low;
        req_ch.status_high <= rq.status_high;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        predicted = predict_touch_result(rq);
        notes_due.push_back(typed ? typed_exp : predicted);
        requests_sent++;
    endtask

    task automatic send_write(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        touch_req_t rq;
        rq            = random_request();
        rq.mode       = MODE_WRITE;
        rq.word_index = idx;
        rq.word_value = value;
        send_request(rq, PRD, ZERO_RESULT);
    endtask

    task automatic send_decode(input logic [15:0] st);
        touch_req_t rq;
        rq             = random_request();
        rq.mode        = MODE_DECODE;
        rq.status_low  = st[7:0];
        rq.status_high = st[15:8];
        send_request(rq, PRD, ZERO_RESULT);
    endtask

    // writes a well-formed fingering layout, then decodes against it
    task automatic run_layout(input layout_t layout);
        logic [WORD_W-1:0] words [$];
        logic [WORD_W-1:0] patterns [$];
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] base;
        logic [FINGER_W-1:0] f;
        int n_groups;
        int n_dec;
        int k;
        n_groups = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 4);
        repeat (n_groups)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w = (layout == LAYOUT_NO_END) ? dead_pattern() : live_pattern();
                words.push_back(w);
                patterns.push_back(w);
            end
            words.push_back(note_word());
        end
        case (layout)
            LAYOUT_TERMINATED:
                words.push_back(END_MARK);
            LAYOUT_NO_END:
                while (words.size() < DEPTH - SCAN_START)
                    words.push_back(($urandom_range(0, 2) == 0) ? note_word() : dead_pattern());
            default:
            begin
                // pattern run to the end of the table, terminators inside it
                words.push_back(CATCH_ALL);
                while (words.size() < DEPTH - SCAN_START)
                    words.push_back(($urandom_range(0, 5) == 0) ? END_MARK : live_pattern());
            end
        endcase
        while (words.size() > DEPTH - SCAN_START)
            void'(words.pop_back());

        base = $urandom;
        case ($urandom_range(0, 5))
            0: base = 32'h0000_0000;
            1: base = 32'hFFFF_FFFF;
            default: ;
        endcase
        send_write(6'd0, base);
        if ($urandom_range(0, 3) == 0)
            send_write(6'd1, $urandom);
        if ($urandom_range(0, 2) == 0)
        begin
            for (k = words.size() - 1; k >= 0; k--)
                send_write(6'(SCAN_START + k), words[k]);
        end
        else
        begin
            for (k = 0; k < words.size(); k++)
                send_write(6'(SCAN_START + k), words[k]);
        end

        n_dec = $urandom_range(3, 10);
        repeat (n_dec)
        begin
            if (patterns.size() > 0 && $urandom_range(0, 1) == 0)
            begin
                w = patterns[$urandom_range(0, patterns.size() - 1)];
                f = (9'($urandom) & ~w[8:0]) | w[24:16];
                send_decode(status_for_fingers(f));
            end
            else
                send_decode(16'($urandom));
        end
    endtask

    // loose writes and decodes; a decode that would read an unwritten word becomes a write
    task automatic run_noise();
        touch_req_t rq;
        repeat ($urandom_range(4, 12))
        begin
            rq = random_request();
            if (rq.mode == MODE_DECODE && !decode_is_safe(rq.status_low, rq.status_high))
                rq.mode = MODE_WRITE;
            if (rq.mode == MODE_WRITE)
            begin
                case ($urandom_range(0, 9))
                    0: rq.word_value = END_MARK;
                    1: rq.word_value = 32'h0000_0000;
                    2: rq.word_value = live_pattern();
                    default: ;
                endcase
            end
            send_request(rq, PRD, ZERO_RESULT);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (notes_due.size() != 0);
    endtask

    initial
    begin : request_source
        dir_row_t row;
        int scenario;
        int pick;
        req_ch.valid       <= 1'b0;
        req_ch.mode        <= MODE_WRITE;
        req_ch.word_index  <= '0;
        req_ch.word_value  <= '0;
        req_ch.status_low  <= '0;
        req_ch.status_high <= '0;
        word_written = '0;
        for (int i = 0; i < DEPTH; i++)
            fingering_shadow[i] = '0;
        do @(posedge clk); while (rst_n !== 1'b1);

        for (int n = 0; n < DIRECTED_N; n++)
        begin
            row = directed_row(n);
            send_request(row.rq, row.typed, row.exp);
        end

        scenario = 0;
        while (requests_sent < ITEM_TARGET)
        begin
            in_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (scenario == 0)
                run_layout(LAYOUT_NO_END);
            else if (scenario == 1)
                run_layout(LAYOUT_RUN_TO_END);
            else if (pick < 4)
                run_noise();
            else if (pick < 6)
                run_layout(LAYOUT_NO_END);
            else if (pick < 9)
                run_layout(LAYOUT_RUN_TO_END);
            else
                run_layout(LAYOUT_TERMINATED);
            if (scenario == DRAIN_AT)
                drain_results();
            scenario++;
        end
        req_ch.valid <= 1'b0;

        while (notes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d table writes, %0d decodes, %0d of them matched",
                 requests_sent, writes_seen, decodes_seen, hits_seen);
        $display("%0d results checked over %0d layouts, %0d errors",
                 results_checked, scenario, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : result_sink
        note_result_t due;
        int stall;
        logic held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            if (!held && results_checked == HOLD_AT)
            begin
                // long hold-off so the block backs up into the request side
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
                stall = out_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (rsp_ch.valid !== 1'b1);

            if (notes_due.size() == 0)
                flag_error($sformatf("unexpected result fingers=%h control=%h note=%h found=%b",
                                     rsp_ch.finger_bits, rsp_ch.control_bits,
                                     rsp_ch.note_out, rsp_ch.found));
            else
            begin
                due = notes_due.pop_front();
                if (rsp_ch.finger_bits !== due.finger_bits)
                    flag_error($sformatf("result %0d finger_bits %h, want %h", results_checked,
                                         rsp_ch.finger_bits, due.finger_bits));
                if (rsp_ch.control_bits !== due.control_bits)
                    flag_error($sformatf("result %0d control_bits %h, want %h", results_checked,
                                         rsp_ch.control_bits, due.control_bits));
                if (rsp_ch.note_out !== due.note_out)
                    flag_error($sformatf("result %0d note_out %h, want %h", results_checked,
                                         rsp_ch.note_out, due.note_out));
                if (rsp_ch.found !== due.found)
                    flag_error($sformatf("result %0d found %b, want %b", results_checked,
                                         rsp_ch.found, due.found));
            end
            results_checked++;
            if (results_checked % 64 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
        end
    end

endmodule

/* filelist.f */
src/tfnd_pkg.sv
src/tfnd_in_if.sv
src/tfnd_out_if.sv
src/tfnd_ctrl.sv
src/tfnd_datapath.sv
src/touch_fingering_note_decoder.sv
src/tfnd_checker.sv
bench/tb_touch_fingering_note_decoder.sv
